// ----- rtl/core/btpc_pkg.sv -----
// ----------------------------------------------------------------------------
// btpc_pkg
// Shared types, constants and helpers of the barometric compensation pipeline.
// ----------------------------------------------------------------------------
package btpc_pkg;

	localparam int DivW  = 64;
	localparam int CfgIw = 3;

	typedef enum logic [CfgIw-1:0] {
		REG_TEMP_COEFFS  = 3'd0,
		REG_PRESS_LOW    = 3'd1,
		REG_PRESS_HIGH   = 3'd2,
		REG_PRESS_NINE   = 3'd3
	} cfg_reg_t;

	// values that ride along the divider
	typedef struct packed {
		logic        inv;
		logic [31:0] centi;
		logic [31:0] fine;
	} side_t;

	function automatic logic [31:0] sx16_32(input logic [15:0] v);
		sx16_32 = {{16{v[15]}}, v};
	endfunction

	function automatic logic [63:0] sx16_64(input logic [15:0] v);
		sx16_64 = {{48{v[15]}}, v};
	endfunction

endpackage

// ----- rtl/core/baro_temp_pressure_compensation.sv -----
// ----------------------------------------------------------------------------
// baro_temp_pressure_compensation
// Integer temperature and pressure compensation of a barometric sensor.
// ----------------------------------------------------------------------------
// usage
//   s_axis: one transaction per sample pair, tdata = raw_temperature [19:0],
//           raw_pressure [39:20]
//   m_axis: one transaction per sample pair, tdata = temperature_centi [31:0],
//           fine_temperature [63:32], pressure_q24_8 [95:64];
//           tuser = pressure_invalid
//   cfg:    register writes (index, data), always ready; write only while idle
//           0 temp_coeffs, 1 press_coeffs_low, 2 press_coeffs_high,
//           3 press_coeff_nine; other indexes are ignored
// pipeline: temperature and polynomial terms, the divider (one quotient bit per
//   stage), pressure correction, one output register
// throughput: one sample pair per cycle while the output is not stalled, set by
//   the fully pipelined divider and the two-stage 64-bit multipliers
// reset: all valid bits clear, coefficients return to zero
// stall: when the output holds a result that is not taken, the whole pipeline
//   freezes and s_axis_tready drops; nothing is lost or repeated
// ----------------------------------------------------------------------------
module baro_temp_pressure_compensation import btpc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	input  logic [39:0]      s_axis_tdata,   // raw_temperature, raw_pressure
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	output logic [95:0]      m_axis_tdata,   // temperature_centi, fine_temperature,
	                                         // pressure_q24_8
	output logic             m_axis_tuser,   // pressure_invalid
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CfgIw-1:0] cfg_index,
	input  logic [63:0]      cfg_data
);

	// configuration registers
	logic [47:0] temp_coeffs_q;
	logic [63:0] plow_q;
	logic [63:0] phigh_q;
	logic [15:0] p9_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_coeffs_q <= '0;
			plow_q        <= '0;
			phigh_q       <= '0;
			p9_q          <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_TEMP_COEFFS: temp_coeffs_q <= cfg_data[47:0];
				REG_PRESS_LOW:   plow_q        <= cfg_data;
				REG_PRESS_HIGH:  phigh_q       <= cfg_data;
				REG_PRESS_NINE:  p9_q          <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// coefficient views
	logic [31:0] t1, t2, t3;
	logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;

	assign t1 = {16'd0, temp_coeffs_q[15:0]};
	assign t2 = sx16_32(temp_coeffs_q[31:16]);
	assign t3 = sx16_32(temp_coeffs_q[47:32]);
	assign p1 = {48'd0, plow_q[15:0]};
	assign p2 = sx16_64(plow_q[31:16]);
	assign p3 = sx16_64(plow_q[47:32]);
	assign p4 = sx16_64(plow_q[63:48]);
	assign p5 = sx16_64(phigh_q[15:0]);
	assign p6 = sx16_64(phigh_q[31:16]);
	assign p7 = sx16_64(phigh_q[47:32]);
	assign p8 = sx16_64(phigh_q[63:48]);
	assign p9 = sx16_64(p9_q);

	// global advance: the output register is free or being emptied
	logic en;
	logic out_vld_q;

	assign en            = !out_vld_q || m_axis_tready;
	assign s_axis_tready = en;

	// valid and carry lines of the front part
	logic        vld_s   [1:17];
	logic [19:0] adcp_s  [1:14];
	logic [31:0] fine_s  [6:17];
	logic [31:0] centi_s [7:17];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= 17; i++) vld_s[i] <= 1'b0;
		end else if (en) begin
			vld_s[1] <= s_axis_tvalid;
			for (int i = 2; i <= 17; i++) vld_s[i] <= vld_s[i-1];
		end
	end

	// temperature path
	logic [19:0] adct_s1;
	logic [31:0] x1_s2, d_s2;
	logic [31:0] m1_s3, dd_s3;
	logic [31:0] a_s4, e_s4;
	logic [31:0] a_s5, m2_s5;
	logic [63:0] v1_s7;
	logic [31:0] fine_c;

	assign fine_c = a_s5 + 32'($signed(m2_s5) >>> 14);

	always_ff @(posedge clk) begin
		if (en) begin
			adct_s1   <= s_axis_tdata[19:0];
			adcp_s[1] <= s_axis_tdata[39:20];
			for (int i = 2; i <= 14; i++) adcp_s[i] <= adcp_s[i-1];

			x1_s2 <= 32'(adct_s1 >> 3) - (t1 << 1);
			d_s2  <= 32'(adct_s1 >> 4) - t1;
			m1_s3 <= 32'(x1_s2 * t2);
			dd_s3 <= 32'(d_s2 * d_s2);
			a_s4  <= 32'($signed(m1_s3) >>> 11);
			e_s4  <= 32'($signed(dd_s3) >>> 12);
			a_s5  <= a_s4;
			m2_s5 <= 32'(e_s4 * t3);
			fine_s[6] <= fine_c;
			for (int i = 7; i <= 17; i++) fine_s[i] <= fine_s[i-1];

			// fine * 5 + 128, arithmetic shift by 8
			centi_s[7] <= 32'($signed(32'((fine_s[6] << 2) + fine_s[6] + 32'd128)) >>> 8);
			for (int i = 8; i <= 17; i++) centi_s[i] <= centi_s[i-1];
			v1_s7 <= {{32{fine_s[6][31]}}, fine_s[6]} - 64'd128000;
		end
	end

	// pressure terms: squares and linear products of v1
	logic [63:0] sq_s9, m5_s9, m2p_s9;

	btpc_mul64 u_mul_sq  (.clk(clk), .en(en), .a(v1_s7), .b(v1_s7), .p(sq_s9));
	btpc_mul64 u_mul_p5  (.clk(clk), .en(en), .a(v1_s7), .b(p5),    .p(m5_s9));
	btpc_mul64 u_mul_p2  (.clk(clk), .en(en), .a(v1_s7), .b(p2),    .p(m2p_s9));

	logic [63:0] sq6_s11, sq3_s11;

	btpc_mul64 u_mul_p6  (.clk(clk), .en(en), .a(sq_s9), .b(p6), .p(sq6_s11));
	btpc_mul64 u_mul_p3  (.clk(clk), .en(en), .a(sq_s9), .b(p3), .p(sq3_s11));

	logic [63:0] m5_s10, m5_s11, m2p_s10, m2p_s11;
	logic [63:0] v2_s12, v1b_s12, v2_s13, v2_s14;
	logic [63:0] pc_s14;
	logic [63:0] v1c_s15, num0_s15, v1c_s16, v1c_s17;
	logic [63:0] num_s17;

	btpc_mul64 u_mul_p1 (
		.clk(clk), .en(en), .a(v1b_s12 + (64'd1 << 47)), .b(p1), .p(pc_s14)
	);

	btpc_mul64 u_mul_k (
		.clk(clk), .en(en), .a(num0_s15), .b(64'd3125), .p(num_s17)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			m5_s10  <= m5_s9;
			m5_s11  <= m5_s10;
			m2p_s10 <= m2p_s9;
			m2p_s11 <= m2p_s10;
			v2_s12  <= sq6_s11 + (m5_s11 << 17) + (p4 << 35);
			v1b_s12 <= 64'($signed(sq3_s11) >>> 8) + (m2p_s11 << 12);
			v2_s13  <= v2_s12;
			v2_s14  <= v2_s13;
			v1c_s15  <= 64'($signed(pc_s14) >>> 33);
			num0_s15 <= ((64'd1048576 - 64'(adcp_s[14])) << 31) - v2_s14;
			v1c_s16  <= v1c_s15;
			v1c_s17  <= v1c_s16;
		end
	end

	// division of the scaled numerator by v1, on magnitudes
	logic        inv_c;
	logic [63:0] dend_mag, dsor_mag;
	side_t       side_in, side_out;
	logic        dvld;
	logic [63:0] dq;

	assign inv_c    = (v1c_s17 == 64'd0);
	assign dend_mag = num_s17[63] ? (64'd0 - num_s17) : num_s17;
	// zero divisor is replaced so the divider stays well defined
	assign dsor_mag = inv_c ? 64'd1 : (v1c_s17[63] ? (64'd0 - v1c_s17) : v1c_s17);
	assign side_in  = '{inv: inv_c, centi: centi_s[17], fine: fine_s[17]};

	btpc_sdiv #(.W(DivW), .SW($bits(side_t))) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s[17]),
		.dividend  (dend_mag),
		.divisor   (dsor_mag),
		.in_neg    (num_s17[63] ^ v1c_s17[63]),
		.in_side   (side_in),
		.out_valid (dvld),
		.quotient  (dq),
		.out_side  (side_out)
	);

	// pressure correction after the division
	logic        pvld_s [18:23];
	side_t       side_s [18:23];
	logic [63:0] p_s    [18:22];
	logic [63:0] ps_c;
	logic [63:0] pss_s20, p8p_s20;
	logic [63:0] w2r_s21, w2r_s22;
	logic [63:0] w1r_s22;
	logic [63:0] sum_s23;
	logic [63:0] pfin_c;

	assign ps_c = 64'($signed(p_s[18]) >>> 13);

	btpc_mul64 u_mul_ps  (.clk(clk), .en(en), .a(ps_c),    .b(ps_c),    .p(pss_s20));
	btpc_mul64 u_mul_p8  (.clk(clk), .en(en), .a(p8),      .b(p_s[18]), .p(p8p_s20));
	btpc_mul64 u_mul_p9  (.clk(clk), .en(en), .a(pss_s20), .b(p9),      .p(w1r_s22));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 18; i <= 23; i++) pvld_s[i] <= 1'b0;
		end else if (en) begin
			pvld_s[18] <= dvld;
			for (int i = 19; i <= 23; i++) pvld_s[i] <= pvld_s[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s[18]    <= dq;
			side_s[18] <= side_out;
			for (int i = 19; i <= 22; i++) p_s[i] <= p_s[i-1];
			for (int i = 19; i <= 23; i++) side_s[i] <= side_s[i-1];
			w2r_s21 <= p8p_s20;
			w2r_s22 <= w2r_s21;
			sum_s23 <= p_s[22] + 64'($signed(w1r_s22) >>> 25)
			         + 64'($signed(w2r_s22) >>> 19);
		end
	end

	assign pfin_c = 64'($signed(sum_s23) >>> 8) + (p7 << 4);

	// output register
	logic [95:0] data_q;
	logic        inv_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= pvld_s[23];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_q <= {side_s[23].inv ? 32'd0 : pfin_c[31:0],
			           side_s[23].fine, side_s[23].centi};
			inv_q  <= side_s[23].inv;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = data_q;
	assign m_axis_tuser  = inv_q;

endmodule

// ----- rtl/core/btpc_mul64.sv -----
// ----------------------------------------------------------------------------
// btpc_mul64
// Two-stage 64x64 multiplier keeping the low 64 bits, built of 32x32 products.
// ----------------------------------------------------------------------------
module btpc_mul64 import btpc_pkg::*; (
	input  logic        clk,
	input  logic        en,
	input  logic [63:0] a,
	input  logic [63:0] b,
	output logic [63:0] p
);

	logic [63:0] ll_s1;
	logic [31:0] lh_s1;
	logic [31:0] hl_s1;
	logic [63:0] p_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			ll_s1 <= 64'(a[31:0]) * 64'(b[31:0]);
			lh_s1 <= 32'(a[31:0] * b[63:32]);
			hl_s1 <= 32'(a[63:32] * b[31:0]);
			p_s2  <= ll_s1 + {32'(lh_s1 + hl_s1), 32'd0};
		end
	end

	assign p = p_s2;

endmodule

// ----- rtl/core/btpc_sdiv.sv -----
// ----------------------------------------------------------------------------
// btpc_sdiv
// Pipelined restoring divider on magnitudes, one quotient bit per stage,
// with sign fix-up at the end and a side payload carried alongside.
// ----------------------------------------------------------------------------
module btpc_sdiv import btpc_pkg::*; #(
	parameter int W  = DivW,
	parameter int SW = $bits(side_t)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [W-1:0]  dividend,
	input  logic [W-1:0]  divisor,
	input  logic          in_neg,
	input  logic [SW-1:0] in_side,
	output logic          out_valid,
	output logic [W-1:0]  quotient,
	output logic [SW-1:0] out_side
);

	logic [W-1:0]  rem_s  [0:W];
	logic [W-1:0]  num_s  [0:W];
	logic [W-1:0]  div_s  [0:W];
	logic          neg_s  [0:W];
	logic [SW-1:0] side_s [0:W];
	logic          vld_s  [0:W];

	assign rem_s[0]  = '0;
	assign num_s[0]  = dividend;
	assign div_s[0]  = divisor;
	assign neg_s[0]  = in_neg;
	assign side_s[0] = in_side;
	assign vld_s[0]  = in_valid;

	for (genvar i = 0; i < W; i++) begin : g_step
		logic [W:0] trial;
		logic [W:0] diff;
		logic       ge;

		assign trial = {rem_s[i], num_s[i][W-1]};
		assign diff  = trial - {1'b0, div_s[i]};
		assign ge    = (trial >= {1'b0, div_s[i]});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (en) begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1]  <= ge ? diff[W-1:0] : trial[W-1:0];
				num_s[i+1]  <= {num_s[i][W-2:0], ge};
				div_s[i+1]  <= div_s[i];
				neg_s[i+1]  <= neg_s[i];
				side_s[i+1] <= side_s[i];
			end
		end
	end

	assign out_valid = vld_s[W];
	assign quotient  = neg_s[W] ? (W'(0) - num_s[W]) : num_s[W];
	assign out_side  = side_s[W];

endmodule

// ----- rtl/core/btpc_check.sv -----
// ----------------------------------------------------------------------------
// btpc_check
// Port-level checks of the compensation block, bound to the top level.
// ----------------------------------------------------------------------------
module btpc_check import btpc_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             s_axis_tvalid,
	input logic             s_axis_tready,
	input logic [39:0]      s_axis_tdata,
	input logic             m_axis_tvalid,
	input logic             m_axis_tready,
	input logic [95:0]      m_axis_tdata,
	input logic             m_axis_tuser,
	input logic             cfg_valid,
	input logic             cfg_ready,
	input logic [CfgIw-1:0] cfg_index,
	input logic [63:0]      cfg_data
);

	// input side is open exactly when the output can move
	a_ready_follows_out: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready == (!m_axis_tvalid || m_axis_tready))
		else $error("input ready does not follow output state");

	// an invalid pressure transaction carries zero pressure
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[95:64] == 32'd0))
		else $error("invalid pressure with nonzero value");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=>
		(m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
		else $error("stalled result changed");

	// configuration port never blocks
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write blocked");

endmodule

bind baro_temp_pressure_compensation btpc_check u_btpc_check (.*);

// ----- dv/baro_temp_pressure_compensation_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// baro_temp_pressure_compensation_tb
// Drives raw sample pairs through the compensation pipeline under several
// coefficient sets, predicts each result in integer arithmetic and compares
// every output transaction field by field, with random gaps on both sides.
// ----------------------------------------------------------------------------
module baro_temp_pressure_compensation_tb;
	import btpc_pkg::*;

	localparam int Latency = 88;

	typedef struct packed {
		logic        inv;
		logic [31:0] press;
		logic [31:0] fine;
		logic [31:0] centi;
	} comp_result_t;

	logic             clk;
	logic             arst_n;
	logic             s_axis_tvalid;
	logic             s_axis_tready;
	logic [39:0]      s_axis_tdata;   // raw_temperature, raw_pressure
	logic             m_axis_tvalid;
	logic             m_axis_tready;
	logic [95:0]      m_axis_tdata;   // temperature_centi, fine_temperature, pressure_q24_8
	logic             m_axis_tuser;   // pressure_invalid
	logic             cfg_valid;
	logic             cfg_ready;
	logic [CfgIw-1:0] cfg_index;
	logic [63:0]      cfg_data;

	// coefficient copies kept by the predictor
	logic [47:0] coef_temp;
	logic [63:0] coef_plow;
	logic [63:0] coef_phigh;
	logic [15:0] coef_p9;

	comp_result_t expected_q[$];
	int           error_count;
	int           hold_off;        // long receiver stall requested by a test
	bit           sink_random;

	baro_temp_pressure_compensation uut (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// generous limit: ~1100 items with random idle gaps on both sides, plus latency
	initial begin
		#5_000_000;
		$display("Test completed with failures");
		$finish;
	end

	function automatic logic [31:0] asr32(input logic [31:0] x, input int n);
		return $signed(x) >>> n;
	endfunction

	function automatic logic [63:0] asr64(input logic [63:0] x, input int n);
		return $signed(x) >>> n;
	endfunction

	// integer compensation of one sample pair
	function automatic comp_result_t compensate(input logic [19:0] adc_t_raw,
	                                            input logic [19:0] adc_p_raw);
		comp_result_t r;
		logic [31:0] adc_t, t1, t2, t3, a, d, b, fine;
		logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
		logic [63:0] v1, v2, p, num, ma, mb, q, ps, w1, w2;
		logic        na, nb;
		adc_t = {12'd0, adc_t_raw};
		t1 = {16'd0, coef_temp[15:0]};
		t2 = {{16{coef_temp[31]}}, coef_temp[31:16]};
		t3 = {{16{coef_temp[47]}}, coef_temp[47:32]};
		a = asr32(((adc_t >> 3) - (t1 << 1)) * t2, 11);
		d = (adc_t >> 4) - t1;
		b = asr32(asr32(d * d, 12) * t3, 14);
		fine = a + b;
		r.fine = fine;
		r.centi = asr32(fine * 32'd5 + 32'd128, 8);
		p1 = {48'd0, coef_plow[15:0]};
		p2 = {{48{coef_plow[31]}}, coef_plow[31:16]};
		p3 = {{48{coef_plow[47]}}, coef_plow[47:32]};
		p4 = {{48{coef_plow[63]}}, coef_plow[63:48]};
		p5 = {{48{coef_phigh[15]}}, coef_phigh[15:0]};
		p6 = {{48{coef_phigh[31]}}, coef_phigh[31:16]};
		p7 = {{48{coef_phigh[47]}}, coef_phigh[47:32]};
		p8 = {{48{coef_phigh[63]}}, coef_phigh[63:48]};
		p9 = {{48{coef_p9[15]}}, coef_p9};
		v1 = {{32{fine[31]}}, fine} - 64'd128000;
		v2 = v1 * v1 * p6;
		v2 += (v1 * p5) << 17;
		v2 += p4 << 35;
		v1 = asr64(v1 * v1 * p3, 8) + ((v1 * p2) << 12);
		v1 = asr64(((64'd1 << 47) + v1) * p1, 33);
		r.press = '0;
		r.inv = 1'b0;
		if (v1 == 64'd0) begin
			r.inv = 1'b1;
		end else begin
			p = 64'd1048576 - {44'd0, adc_p_raw};
			num = ((p << 31) - v2) * 64'd3125;
			na = num[63];
			nb = v1[63];
			ma = na ? -num : num;
			mb = nb ? -v1 : v1;
			q = ma / mb;
			p = (na != nb) ? -q : q;
			ps = asr64(p, 13);
			w1 = asr64(p9 * ps * ps, 25);
			w2 = asr64(p8 * p, 19);
			p = asr64(p + w1 + w2, 8) + (p7 << 4);
			r.press = p[31:0];
		end
		return r;
	endfunction

	// one register write while the pipeline is idle, then a quiet gap with cfg_valid low
	task automatic write_coeff(input cfg_reg_t idx, input logic [63:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_TEMP_COEFFS: coef_temp = value[47:0];
			REG_PRESS_LOW:   coef_plow = value;
			REG_PRESS_HIGH:  coef_phigh = value;
			REG_PRESS_NINE:  coef_p9 = value[15:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_coeffs(input logic [47:0] t, input logic [63:0] pl,
	                          input logic [63:0] ph, input logic [15:0] p9);
		write_coeff(REG_TEMP_COEFFS, {16'd0, t});
		write_coeff(REG_PRESS_LOW, pl);
		write_coeff(REG_PRESS_HIGH, ph);
		write_coeff(REG_PRESS_NINE, {48'd0, p9});
	endtask

	// one sample pair transaction; gap drawn per item unless told otherwise
	// valid stays up after the handshake until the next gap or drain
	task automatic send_sample(input logic [19:0] rt, input logic [19:0] rp,
	                           input bit gaps = 1);
		int gap;
		gap = gaps ? $urandom_range(0, 3) : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {rp, rt};
		do @(posedge clk); while (!s_axis_tready);
		expected_q.push_back(compensate(rt, rp));
		@(negedge clk);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (expected_q.size() != 0) @(negedge clk);
		repeat (Latency + 8) @(negedge clk);
	endtask

	// realistic factory coefficients with small random jitter
	task automatic load_typical();
		set_coeffs({16'hFC18, 16'd26435, 16'd27504},
		           {16'd2855, 16'hF59D, 16'hD5C6, 16'd36477},
		           {16'd15500, 16'hBF0F, 16'hFFF9, 16'd140},
		           16'd6000 + 16'($urandom_range(0, 15)));
	endtask

	// receiver: random wait before each result when sink_random is set, long hold-off when requested
	initial begin
		int wait_n;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off > 0) begin
				m_axis_tready <= 1'b0;
				repeat (hold_off) @(negedge clk);
				hold_off = 0;
			end
			wait_n = sink_random ? $urandom_range(0, 3) : 0;
			if (wait_n > 0) begin
				m_axis_tready <= 1'b0;
				repeat (wait_n) @(negedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	// result checker: every output transaction against the oldest expectation
	always @(posedge clk) begin
		comp_result_t exp_r, got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = {m_axis_tuser, m_axis_tdata[95:64], m_axis_tdata[63:32],
			       m_axis_tdata[31:0]};
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result %h", $time, got);
				error_count++;
			end else begin
				exp_r = expected_q.pop_front();
				if (got.centi !== exp_r.centi) begin
					$display("%0t: temperature_centi expected %h actual %h",
					         $time, exp_r.centi, got.centi);
					error_count++;
				end
				if (got.fine !== exp_r.fine) begin
					$display("%0t: fine_temperature expected %h actual %h",
					         $time, exp_r.fine, got.fine);
					error_count++;
				end
				if (got.press !== exp_r.press) begin
					$display("%0t: pressure_q24_8 expected %h actual %h",
					         $time, exp_r.press, got.press);
					error_count++;
				end
				if (got.inv !== exp_r.inv) begin
					$display("%0t: pressure_invalid expected %b actual %b",
					         $time, exp_r.inv, got.inv);
					error_count++;
				end
			end
		end
	end

	// zero coefficients after reset: divisor zero, pressure flagged invalid
	task automatic test_reset_coeffs();
		send_sample(20'd0, 20'd0);
		send_sample(20'hFFFFF, 20'hFFFFF);
		send_sample(20'd519888, 20'd415148);
		drain();
	endtask

	// field extremes and out-of-range register indexes under typical coefficients
	task automatic test_directed_extremes();
		load_typical();
		write_coeff(cfg_reg_t'(3'd5), 64'hFFFF_FFFF_FFFF_FFFF);
		write_coeff(cfg_reg_t'(3'd7), 64'h1234);
		send_sample(20'd0, 20'd0);
		send_sample(20'hFFFFF, 20'd0);
		send_sample(20'd0, 20'hFFFFF);
		send_sample(20'hFFFFF, 20'hFFFFF);
		send_sample(20'hAAAAA, 20'h55555);
		send_sample(20'h55555, 20'hAAAAA);
		send_sample(20'd519888, 20'd415148);
		drain();
	endtask

	// extreme coefficient sets: all ones, signed limits
	task automatic test_coeff_extremes();
		set_coeffs(48'hFFFF_FFFF_FFFF, '1, '1, 16'hFFFF);
		send_sample(20'hFFFFF, 20'd0);
		send_sample(20'd0, 20'hFFFFF);
		send_sample(20'd123456, 20'd654321);
		drain();
		set_coeffs({16'h8000, 16'h8000, 16'hFFFF}, {16'h8000, 16'h8000, 16'h8000, 16'hFFFF},
		           {16'h8000, 16'h8000, 16'h8000, 16'h8000}, 16'h8000);
		send_sample(20'hFFFFF, 20'hFFFFF);
		send_sample(20'd0, 20'd0);
		send_sample(20'd777777, 20'd1);
		drain();
		set_coeffs({16'h7FFF, 16'h7FFF, 16'd0}, {16'h7FFF, 16'h7FFF, 16'h7FFF, 16'd1},
		           {16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF}, 16'h7FFF);
		send_sample(20'hFFFFF, 20'hFFFFF);
		send_sample(20'd0, 20'd0);
		send_sample(20'd40000, 20'd999999);
		drain();
	endtask

	// long receiver stall while the sender keeps offering back-to-back items
	task automatic test_backpressure();
		load_typical();
		hold_off = 300;
		repeat (150) send_sample(20'($urandom()), 20'($urandom()), 0);
		drain();
	endtask

	// random samples, mostly near realistic coefficients, some fully random sets
	task automatic test_random(input int items);
		int n;
		n = 0;
		while (n < items) begin
			if ($urandom_range(0, 2) == 0)
				set_coeffs({$urandom(), 16'($urandom())}, {$urandom(), $urandom()},
				           {$urandom(), $urandom()}, 16'($urandom()));
			else
				load_typical();
			repeat (100) begin
				if ($urandom_range(0, 3) == 0)
					send_sample(20'($urandom()), 20'($urandom()));
				else
					send_sample(20'($urandom_range(380000, 620000)),
					            20'($urandom_range(200000, 500000)));
				n++;
			end
			drain();
		end
	endtask

	initial begin
		error_count = 0;
		hold_off = 0;
		sink_random = 1'b0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_TEMP_COEFFS;
		cfg_data = '0;
		coef_temp = '0;
		coef_plow = '0;
		coef_phigh = '0;
		coef_p9 = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_reset_coeffs();
		sink_random = 1'b1;
		test_directed_extremes();
		test_coeff_extremes();
		test_backpressure();
		test_random(880);
		if (error_count == 0 && expected_q.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
